// File: hdl/iptt_pkg.sv
// ----------------------------------------------------------------------------
// iptt_pkg
// Shared types and constants for the indexed priority task table.
// ----------------------------------------------------------------------------
package iptt_pkg;

  localparam int TaskSlots = 256;
  localparam int SlotW     = $clog2(TaskSlots);
  localparam int PriW      = 32;
  localparam int UserW     = 16;
  localparam int TaskW     = 8;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_EDIT   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_EXEC   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_USER,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic do_write;
    logic scan_clear;
    logic scan_issue;
    logic user_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// File: hdl/iptt_ctrl.sv
// ----------------------------------------------------------------------------
// iptt_ctrl
// Sequencer: accepts items, runs the table scan for execute-top and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module iptt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  iptt_pkg::status_t status,
  output iptt_pkg::cmd_t    cmd
);

  iptt_pkg::state_t state, state_next;
  logic             is_exec;

  assign is_exec = (iptt_pkg::mode_t'(mode) == iptt_pkg::MODE_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iptt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iptt_pkg::ST_IDLE: begin
        if (in_valid && is_exec) state_next = iptt_pkg::ST_SCAN;
      end
      iptt_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = iptt_pkg::ST_DRAIN;
      end
      iptt_pkg::ST_DRAIN: begin
        state_next = iptt_pkg::ST_USER;
      end
      iptt_pkg::ST_USER: begin
        state_next = iptt_pkg::ST_RESULT;
      end
      iptt_pkg::ST_RESULT: begin
        if (status.out_free) state_next = iptt_pkg::ST_IDLE;
      end
      default: state_next = iptt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      iptt_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.do_write   = in_valid && !is_exec;
        cmd.scan_clear = in_valid && is_exec;
      end
      iptt_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
      end
      iptt_pkg::ST_DRAIN: begin
      end
      iptt_pkg::ST_USER: begin
        cmd.user_read = 1'b1;
      end
      iptt_pkg::ST_RESULT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/iptt_datapath.sv
// ----------------------------------------------------------------------------
// iptt_datapath
// Task table storage, running-maximum scan and output register.
// ----------------------------------------------------------------------------
module iptt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  iptt_pkg::cmd_t                cmd,
  output iptt_pkg::status_t             status,
  input  logic [1:0]                    mode,
  input  logic [iptt_pkg::UserW-1:0]    user_id,
  input  logic [iptt_pkg::TaskW-1:0]    task_id,
  input  logic [iptt_pkg::PriW-1:0]     priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [iptt_pkg::UserW-1:0]    user_id_out
);

  logic [iptt_pkg::TaskSlots-1:0] entry_valid;
  logic [iptt_pkg::PriW-1:0]      pri_mem  [iptt_pkg::TaskSlots];
  logic [iptt_pkg::UserW-1:0]     user_mem [iptt_pkg::TaskSlots];

  logic [iptt_pkg::SlotW-1:0] wr_idx;
  logic [iptt_pkg::SlotW-1:0] scan_idx;
  logic [iptt_pkg::SlotW-1:0] cmp_idx;
  logic                       cmp_pend;
  logic [iptt_pkg::PriW-1:0]  pri_rdata;
  logic [iptt_pkg::UserW-1:0] user_rdata;
  logic                       have;
  logic [iptt_pkg::PriW-1:0]  best_pri;
  logic [iptt_pkg::SlotW-1:0] best_idx;
  logic                       take;
  logic                       pri_we;
  logic                       user_we;
  iptt_pkg::mode_t            op;

  assign op     = iptt_pkg::mode_t'(mode);
  assign wr_idx = task_id[iptt_pkg::SlotW-1:0];

  always_comb begin
    pri_we  = 1'b0;
    user_we = 1'b0;
    if (cmd.do_write) begin
      unique case (op)
        iptt_pkg::MODE_ADD: begin
          pri_we  = 1'b1;
          user_we = 1'b1;
        end
        iptt_pkg::MODE_EDIT:   pri_we = entry_valid[wr_idx];
        iptt_pkg::MODE_REMOVE: pri_we = 1'b0;
        iptt_pkg::MODE_EXEC:   pri_we = 1'b0;
        default:               pri_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pri_we) pri_mem[wr_idx] <= priority_req;
    pri_rdata <= pri_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (user_we) user_mem[wr_idx] <= user_id;
    if (cmd.user_read) user_rdata <= user_mem[best_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.do_write && op == iptt_pkg::MODE_ADD) begin
      entry_valid[wr_idx] <= 1'b1;
    end else if (cmd.do_write && op == iptt_pkg::MODE_REMOVE) begin
      entry_valid[wr_idx] <= 1'b0;
    end else if (cmd.out_load && have) begin
      entry_valid[best_idx] <= 1'b0;
    end
  end

  assign take = cmp_pend && entry_valid[cmp_idx] && (!have || pri_rdata >= best_pri);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
      have     <= 1'b0;
      scan_idx <= '0;
    end else begin
      cmp_pend <= cmd.scan_issue;
      if (cmd.scan_clear) begin
        scan_idx <= '0;
        have     <= 1'b0;
      end else begin
        if (cmd.scan_issue) scan_idx <= scan_idx + 1'b1;
        if (take) have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (take) begin
      best_pri <= pri_rdata;
      best_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= have;
      user_id_out <= have ? user_rdata : '0;
    end
  end

  assign status.scan_last = cmd.scan_issue &&
                            (scan_idx == iptt_pkg::SlotW'(iptt_pkg::TaskSlots - 1));
  assign status.out_free  = !out_valid || out_ready;

endmodule

// File: hdl/indexed_priority_task_table.sv
// ----------------------------------------------------------------------------
// indexed_priority_task_table
// Task table indexed by task id with max-priority execute-top.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries mode, user_id, task_id and
// priority_req. Add, edit and remove complete in the cycle of the transfer
// and produce no result; the next item is taken in the following cycle.
// Execute-top scans all 256 slots through the priority memory read port,
// one slot per cycle, then reads the winner's user id: the result appears
// on the output channel (out_valid/out_ready, found, user_id_out) after the
// drain, user and result states, and the next item is taken as it appears.
// A tie in priority goes to the larger task id; an empty table gives
// found = 0 and user_id_out = 0.
// The output register holds a result until it is taken; while it is full
// further add, edit and remove items are still taken, and a following
// execute-top waits at its last step until the register frees up.
// Reset clears all valid bits, the sequencer and the output valid flag;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_priority_task_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [iptt_pkg::UserW-1:0]    user_id,
  input  logic [iptt_pkg::TaskW-1:0]    task_id,
  input  logic [iptt_pkg::PriW-1:0]     priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [iptt_pkg::UserW-1:0]    user_id_out
);

  iptt_pkg::cmd_t    cmd;
  iptt_pkg::status_t status;

  iptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  iptt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .mode         (mode),
    .user_id      (user_id),
    .task_id      (task_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .user_id_out  (user_id_out)
  );

endmodule
